// File: rtl/fsfe_pkg.sv
`timescale 1ns / 1ps

package fsfe_pkg;

    // fixed field widths
    localparam int COORD_W    = 16;
    localparam int SUM_W      = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int TT_W       = 2 * SUM_W;
    localparam int CUBE_W     = SQ_W + SUM_W;
    localparam int OUT_W      = 24;
    localparam int NODE_W     = 3;
    localparam int KIND_W     = 2;
    localparam int OUT_MAX    = 8388607;
    localparam int OUT_MIN    = -8388608;

    // coefficient widths for the constant, linear, quadratic and cubic terms
    localparam int P0W = 4;
    localparam int P1W = 21;
    localparam int P2W = 38;
    localparam int P3W = 52;

    // default fixed-point formats
    localparam int COORD_FRAC_BITS_DEF = 14;
    localparam int OUT_FRAC_BITS_DEF   = 16;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_TRI3 = 2'd0,
        KIND_TRI6 = 2'd1,
        KIND_TRI7 = 2'd2,
        KIND_QUAD4 = 2'd3
    } element_kind_t;

    // one point with its shared products
    typedef struct packed {
        element_kind_t             kind;
        logic signed [COORD_W-1:0] r;
        logic signed [COORD_W-1:0] s;
        logic signed [SUM_W-1:0]   t;
        logic signed [SQ_W-1:0]    rs;
        logic signed [SQ_W-1:0]    rr;
        logic signed [SQ_W-1:0]    ss;
        logic signed [TT_W-1:0]    tt;
        logic signed [CUBE_W-1:0]  rst;
    } point_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // index of the final node of an element
    function automatic logic [NODE_W-1:0] last_node_of(input element_kind_t kind);
        logic [NODE_W-1:0] idx;
        unique case (kind)
            KIND_TRI3:  idx = NODE_W'(2);
            KIND_TRI6:  idx = NODE_W'(5);
            KIND_TRI7:  idx = NODE_W'(6);
            KIND_QUAD4: idx = NODE_W'(3);
            default:    idx = NODE_W'(2);
        endcase
        return idx;
    endfunction

endpackage

// File: rtl/fem_2d_shape_function_evaluator_unit.sv
`timescale 1ns / 1ps

// channel    dir  handshake               payload
// s_         in   s_tvalid / s_tready     one point: coord_first, coord_second
// m_         out  m_tvalid / m_tready     one node: values, node in tuser, last in tlast
// cfg_       in   cfg_valid / cfg_ready   element_kind
//
// A point gives 3, 4, 6 or 7 node results, one per cycle while m_tready is high, as many
// as its element has nodes; the node sequencer in the back end sets that pace.
// Each point passes front stages one and two, the queue, then the coefficient, sum and output stages.
// aresetn is synchronous, active low: clears all valid flags and selects the 3-node triangle.
// m_tready low holds the output register; the back end then fills, the two-entry queue
// absorbs points from the front end, and s_tready falls once the queue and both front stages are full.

module fem_2d_shape_function_evaluator_unit import fsfe_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [KIND_W-1:0] cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // coord_first[15:0], coord_second[31:16]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [71:0]       m_tdata,   // shape_value[23:0], deriv_first[47:24], deriv_second[71:48]
    output logic [NODE_W-1:0] m_tuser,   // node_index[2:0]
    output logic              m_tlast
);

    element_kind_t           element_kind_reg;
    logic                    fq_valid;
    logic                    fq_ready;
    point_t                  fq_point;
    logic                    qb_valid;
    logic                    qb_ready;
    point_t                  qb_point;
    logic signed [OUT_W-1:0] value;
    logic signed [OUT_W-1:0] dfirst;
    logic signed [OUT_W-1:0] dsecond;

    // element selection register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_kind_reg <= KIND_TRI3;
        end else if (cfg_valid) begin
            element_kind_reg <= element_kind_t'(cfg_data);
        end
    end

    fsfe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .kind      (element_kind_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_r      (s_tdata[15:0]),
        .in_s      (s_tdata[31:16]),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_point (fq_point)
    );

    fsfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_point),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_point)
    );

    fsfe_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .OUT_FRAC_BITS   (OUT_FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (qb_valid),
        .in_ready    (qb_ready),
        .in_point    (qb_point),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_node    (m_tuser),
        .out_last    (m_tlast),
        .out_value   (value),
        .out_dfirst  (dfirst),
        .out_dsecond (dsecond)
    );

    assign m_tdata = {dsecond, dfirst, value};

endmodule

// File: rtl/fsfe_front.sv
`timescale 1ns / 1ps

module fsfe_front import fsfe_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  element_kind_t             kind,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] in_r,
    input  logic signed [COORD_W-1:0] in_s,
    output logic                      out_valid,
    input  logic                      out_ready,
    output point_t                    out_point
);

    logic                      v1_reg;
    logic                      v2_reg;
    element_kind_t             kind1_reg;
    logic signed [COORD_W-1:0] r1_reg;
    logic signed [COORD_W-1:0] s1_reg;
    logic signed [SUM_W-1:0]   t1_reg;
    logic signed [SQ_W-1:0]    rs1_reg;
    logic signed [SQ_W-1:0]    rr1_reg;
    logic signed [SQ_W-1:0]    ss1_reg;
    logic signed [TT_W-1:0]    tt1_reg;
    point_t                    pt2_reg;
    logic                      st2_ready;
    logic signed [SUM_W-1:0]   t_in;

    // stage readiness
    assign st2_ready = !v2_reg || out_ready;
    assign in_ready  = !v1_reg || st2_ready;
    assign t_in      = SUM_W'(in_r) + SUM_W'(in_s);

    // stage one: squares and cross product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (in_ready) begin
            v1_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            kind1_reg <= kind;
            r1_reg    <= in_r;
            s1_reg    <= in_s;
            t1_reg    <= t_in;
            rs1_reg   <= SQ_W'(in_r) * SQ_W'(in_s);
            rr1_reg   <= SQ_W'(in_r) * SQ_W'(in_r);
            ss1_reg   <= SQ_W'(in_s) * SQ_W'(in_s);
            tt1_reg   <= TT_W'(t_in) * TT_W'(t_in);
        end
    end

    // stage two: cubic product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (st2_ready) begin
            v2_reg <= v1_reg;
        end
        if (st2_ready && v1_reg) begin
            pt2_reg.kind <= kind1_reg;
            pt2_reg.r    <= r1_reg;
            pt2_reg.s    <= s1_reg;
            pt2_reg.t    <= t1_reg;
            pt2_reg.rs   <= rs1_reg;
            pt2_reg.rr   <= rr1_reg;
            pt2_reg.ss   <= ss1_reg;
            pt2_reg.tt   <= tt1_reg;
            pt2_reg.rst  <= CUBE_W'(rs1_reg) * CUBE_W'(t1_reg);
        end
    end

    assign out_valid = v2_reg;
    assign out_point = pt2_reg;

endmodule

// File: rtl/fsfe_queue.sv
`timescale 1ns / 1ps

module fsfe_queue import fsfe_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_valid,
    output logic   push_ready,
    input  point_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output point_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    point_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/fsfe_back.sv
`timescale 1ns / 1ps

module fsfe_back import fsfe_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  point_t                  in_point,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [NODE_W-1:0]       out_node,
    output logic                    out_last,
    output logic signed [OUT_W-1:0] out_value,
    output logic signed [OUT_W-1:0] out_dfirst,
    output logic signed [OUT_W-1:0] out_dsecond
);

    localparam int F     = COORD_FRAC_BITS;
    localparam int XW    = imax(imax(3 * F + P0W, 2 * F + P1W), imax(F + P2W, P3W)) + 2;
    localparam int XQW   = XW + 2;
    localparam int SH    = 3 * F + 2 - OUT_FRAC_BITS;
    localparam int LSH   = (SH < 0) ? -SH : 0;
    localparam int RSH   = (SH > 0) ? SH : 0;
    localparam int YW    = XQW + 1 + LSH;
    localparam logic signed [YW-1:0] HALF   = (RSH > 0) ? (YW'(1) << ((RSH > 0) ? RSH - 1 : 0))
                                                        : '0;
    localparam logic signed [YW-1:0] SAT_HI = YW'(OUT_MAX);
    localparam logic signed [YW-1:0] SAT_LO = YW'(OUT_MIN);

    // node sequencer
    logic [NODE_W-1:0]       cnt_reg;
    logic [NODE_W-1:0]       cnt_next;
    logic                    node_last;

    // coefficient stage
    logic                    vb1_reg;
    logic [NODE_W-1:0]       node1_reg;
    logic                    last1_reg;
    logic                    quad1_reg;
    logic signed [P0W-1:0]   c0_reg [3];
    logic signed [P1W-1:0]   c1_reg [3];
    logic signed [P2W-1:0]   c2_reg [3];
    logic signed [P3W-1:0]   c3_reg [3];
    logic signed [P0W-1:0]   c0 [3];
    logic signed [P1W-1:0]   c1 [3];
    logic signed [P2W-1:0]   c2 [3];
    logic signed [P3W-1:0]   c3 [3];

    // sum stage
    logic                    vb2_reg;
    logic [NODE_W-1:0]       node2_reg;
    logic                    last2_reg;
    logic signed [XQW-1:0]   x_reg [3];
    logic signed [XW-1:0]    xsum [3];
    logic signed [XQW-1:0]   xq [3];

    // output stage
    logic                    vb3_reg;
    logic [NODE_W-1:0]       node3_reg;
    logic                    last3_reg;
    logic signed [OUT_W-1:0] q_reg [3];
    logic signed [YW-1:0]    y [3];
    logic signed [OUT_W-1:0] q [3];

    logic                    b1_ready;
    logic                    b2_ready;
    logic                    b3_ready;

    logic signed [P1W-1:0]   r1;
    logic signed [P1W-1:0]   s1;
    logic signed [P1W-1:0]   t1;
    logic signed [P2W-1:0]   rs2;
    logic signed [P2W-1:0]   rr2;
    logic signed [P2W-1:0]   ss2;
    logic signed [P2W-1:0]   tt2;
    logic signed [P3W-1:0]   rst3;

    assign b3_ready = !vb3_reg || out_ready;
    assign b2_ready = !vb2_reg || b3_ready;
    assign b1_ready = !vb1_reg || b2_ready;

    assign node_last = (cnt_reg == last_node_of(in_point.kind));
    assign in_ready  = b1_ready && node_last;
    assign cnt_next  = node_last ? '0 : cnt_reg + NODE_W'(1);

    assign r1   = P1W'(in_point.r);
    assign s1   = P1W'(in_point.s);
    assign t1   = P1W'(in_point.t);
    assign rs2  = P2W'(in_point.rs);
    assign rr2  = P2W'(in_point.rr);
    assign ss2  = P2W'(in_point.ss);
    assign tt2  = P2W'(in_point.tt);
    assign rst3 = P3W'(in_point.rst);

    // coefficients of value, d/dfirst and d/dsecond for the current node
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c0[j] = '0;
            c1[j] = '0;
            c2[j] = '0;
            c3[j] = '0;
        end
        unique case (in_point.kind)
            KIND_TRI3: begin
                unique case (cnt_reg)
                    3'd0: begin
                        c0[0] = P0W'(1);  c1[0] = -t1;
                        c0[1] = P0W'(-1);
                        c0[2] = P0W'(-1);
                    end
                    3'd1: begin
                        c1[0] = r1;
                        c0[1] = P0W'(1);
                    end
                    3'd2: begin
                        c1[0] = s1;
                        c0[2] = P0W'(1);
                    end
                    default: ;
                endcase
            end
            KIND_TRI6: begin
                unique case (cnt_reg)
                    3'd0: begin
                        c0[0] = P0W'(1);  c1[0] = P1W'(t1 * -3);  c2[0] = tt2 * 2;
                        c0[1] = P0W'(-3); c1[1] = P1W'(t1 * 4);
                        c0[2] = P0W'(-3); c1[2] = P1W'(t1 * 4);
                    end
                    3'd1: begin
                        c1[0] = -r1;      c2[0] = rr2 * 2;
                        c0[1] = P0W'(-1); c1[1] = P1W'(r1 * 4);
                    end
                    3'd2: begin
                        c1[0] = -s1;      c2[0] = ss2 * 2;
                        c0[2] = P0W'(-1); c1[2] = P1W'(s1 * 4);
                    end
                    3'd3: begin
                        c1[0] = P1W'(r1 * 4);  c2[0] = (rr2 + rs2) * -4;
                        c0[1] = P0W'(4);       c1[1] = P1W'(r1 * -8 - s1 * 4);
                        c1[2] = P1W'(r1 * -4);
                    end
                    3'd4: begin
                        c2[0] = rs2 * 4;
                        c1[1] = P1W'(s1 * 4);
                        c1[2] = P1W'(r1 * 4);
                    end
                    3'd5: begin
                        c1[0] = P1W'(s1 * 4);  c2[0] = (rs2 + ss2) * -4;
                        c1[1] = P1W'(s1 * -4);
                        c0[2] = P0W'(4);       c1[2] = P1W'(r1 * -4 - s1 * 8);
                    end
                    default: ;
                endcase
            end
            KIND_TRI7: begin
                unique case (cnt_reg)
                    3'd0: begin
                        c0[0] = P0W'(1);  c1[0] = P1W'(t1 * -3);
                        c2[0] = (rr2 + ss2) * 2 + rs2 * 7;       c3[0] = rst3 * -3;
                        c0[1] = P0W'(-3); c1[1] = P1W'(r1 * 4 + s1 * 7);
                        c2[1] = rs2 * -6 - ss2 * 3;
                        c0[2] = P0W'(-3); c1[2] = P1W'(r1 * 7 + s1 * 4);
                        c2[2] = rs2 * -6 - rr2 * 3;
                    end
                    3'd1: begin
                        c1[0] = -r1;      c2[0] = rr2 * 2 + rs2 * 3;  c3[0] = rst3 * -3;
                        c0[1] = P0W'(-1); c1[1] = P1W'(r1 * 4 + s1 * 3);
                        c2[1] = rs2 * -6 - ss2 * 3;
                        c1[2] = P1W'(r1 * 3);  c2[2] = rr2 * -3 - rs2 * 6;
                    end
                    3'd2: begin
                        c1[0] = -s1;      c2[0] = ss2 * 2 + rs2 * 3;  c3[0] = rst3 * -3;
                        c1[1] = P1W'(s1 * 3);  c2[1] = ss2 * -3 - rs2 * 6;
                        c0[2] = P0W'(-1); c1[2] = P1W'(r1 * 3 + s1 * 4);
                        c2[2] = rr2 * -3 - rs2 * 6;
                    end
                    3'd3: begin
                        c1[0] = P1W'(r1 * 4);  c2[0] = rr2 * -4 - rs2 * 16;
                        c3[0] = rst3 * 12;
                        c0[1] = P0W'(4);       c1[1] = P1W'(r1 * -8 - s1 * 16);
                        c2[1] = rs2 * 24 + ss2 * 12;
                        c1[2] = P1W'(r1 * -16); c2[2] = rr2 * 12 + rs2 * 24;
                    end
                    3'd4: begin
                        c2[0] = rs2 * -8;       c3[0] = rst3 * 12;
                        c1[1] = P1W'(s1 * -8);  c2[1] = rs2 * 24 + ss2 * 12;
                        c1[2] = P1W'(r1 * -8);  c2[2] = rr2 * 12 + rs2 * 24;
                    end
                    3'd5: begin
                        c1[0] = P1W'(s1 * 4);   c2[0] = rs2 * -16 - ss2 * 4;
                        c3[0] = rst3 * 12;
                        c1[1] = P1W'(s1 * -16); c2[1] = rs2 * 24 + ss2 * 12;
                        c0[2] = P0W'(4);        c1[2] = P1W'(r1 * -16 - s1 * 8);
                        c2[2] = rr2 * 12 + rs2 * 24;
                    end
                    3'd6: begin
                        c2[0] = rs2 * 27;       c3[0] = rst3 * -27;
                        c1[1] = P1W'(s1 * 27);  c2[1] = rs2 * -54 - ss2 * 27;
                        c1[2] = P1W'(r1 * 27);  c2[2] = rr2 * -27 - rs2 * 54;
                    end
                    default: ;
                endcase
            end
            KIND_QUAD4: begin
                unique case (cnt_reg)
                    3'd0: begin
                        c0[0] = P0W'(1);  c1[0] = r1 - s1;  c2[0] = -rs2;
                        c0[1] = P0W'(1);  c1[1] = -s1;
                        c0[2] = P0W'(-1); c1[2] = -r1;
                    end
                    3'd1: begin
                        c0[0] = P0W'(1);  c1[0] = r1 + s1;  c2[0] = rs2;
                        c0[1] = P0W'(1);  c1[1] = s1;
                        c0[2] = P0W'(1);  c1[2] = r1;
                    end
                    3'd2: begin
                        c0[0] = P0W'(1);  c1[0] = s1 - r1;  c2[0] = -rs2;
                        c0[1] = P0W'(-1); c1[1] = -s1;
                        c0[2] = P0W'(1);  c1[2] = -r1;
                    end
                    3'd3: begin
                        c0[0] = P0W'(1);  c1[0] = -t1;      c2[0] = rs2;
                        c0[1] = P0W'(-1); c1[1] = s1;
                        c0[2] = P0W'(-1); c1[2] = r1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // coefficient register and node counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb1_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (b1_ready) begin
            vb1_reg <= in_valid;
            if (in_valid) begin
                cnt_reg <= cnt_next;
            end
        end
        if (b1_ready && in_valid) begin
            node1_reg <= cnt_reg;
            last1_reg <= node_last;
            quad1_reg <= (in_point.kind == KIND_QUAD4);
            for (int j = 0; j < 3; j++) begin
                c0_reg[j] <= c0[j];
                c1_reg[j] <= c1[j];
                c2_reg[j] <= c2[j];
                c3_reg[j] <= c3[j];
            end
        end
    end

    // exact sum on a common scale, triangles aligned to the quadrilateral quarter
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            xsum[j] = (XW'(c0_reg[j]) <<< (3 * F)) + (XW'(c1_reg[j]) <<< (2 * F))
                    + (XW'(c2_reg[j]) <<< F) + XW'(c3_reg[j]);
            xq[j]   = quad1_reg ? XQW'(xsum[j]) : (XQW'(xsum[j]) <<< 2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb2_reg <= 1'b0;
        end else if (b2_ready) begin
            vb2_reg <= vb1_reg;
        end
        if (b2_ready && vb1_reg) begin
            node2_reg <= node1_reg;
            last2_reg <= last1_reg;
            for (int j = 0; j < 3; j++) begin
                x_reg[j] <= xq[j];
            end
        end
    end

    // round half up to the output scale, then saturate
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            y[j] = ((YW'(x_reg[j]) <<< LSH) + HALF) >>> RSH;
            if (y[j] > SAT_HI) begin
                q[j] = OUT_W'(OUT_MAX);
            end else if (y[j] < SAT_LO) begin
                q[j] = OUT_W'(OUT_MIN);
            end else begin
                q[j] = y[j][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb3_reg <= 1'b0;
        end else if (b3_ready) begin
            vb3_reg <= vb2_reg;
        end
        if (b3_ready && vb2_reg) begin
            node3_reg <= node2_reg;
            last3_reg <= last2_reg;
            for (int j = 0; j < 3; j++) begin
                q_reg[j] <= q[j];
            end
        end
    end

    assign out_valid   = vb3_reg;
    assign out_node    = node3_reg;
    assign out_last    = last3_reg;
    assign out_value   = q_reg[0];
    assign out_dfirst  = q_reg[1];
    assign out_dsecond = q_reg[2];

endmodule
